FILE: rtl/tpli_pkg.sv
// Shared types, codes and widths for the texture pool lookup and insert block.
package tpli_pkg;

   // Default number of pool entries
   localparam int POOL_DEPTH_DEF = 512;

   // Result field widths
   localparam int STATUS_W  = 3;
   localparam int INDEX_W   = 9;
   localparam int COUNT_W   = 10;

   // Stream widths
   localparam int REQ_DATA_W = 168;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_HIT      = 3'd0,
      ST_REUPLOAD = 3'd1,
      ST_INSERTED = 3'd2,
      ST_FULL     = 3'd3,
      ST_INVALID  = 3'd4,
      ST_DIRTY    = 3'd5
   } status_type;

   // Request mode codes
   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_DIRTY  = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MISS,
      S_DONE
   } state_type;

   // Stored descriptor of one entry; the guest address follows from kind and source
   typedef struct packed {
      logic        is_host;
      logic [31:0] source;
      logic [31:0] size;
      logic        keyed;
      logic [63:0] key_range;
   } desc_type;

   // Outcome of comparing one stored entry against the request
   typedef struct packed {
      logic desc_hit;
      logic guest_hit;
      logic hash_same;
   } cmp_flags_type;

endpackage

FILE: rtl/tpli_entry_cmp.sv
// Compare unit shared by every scan step: one stored entry against the request.
module tpli_entry_cmp
   import tpli_pkg::*;
(
   input  desc_type      entry_desc,
   input  logic [31:0]   entry_hash,
   input  desc_type      req_desc,
   input  logic [31:0]   req_hash,
   output cmp_flags_type flags
);

   logic        base_eq;
   logic        range_ok;
   logic [31:0] entry_guest;

   // Match on size, keyed flag, kind and id; key range only when keyed
   assign base_eq = (entry_desc.size == req_desc.size) &&
                    (entry_desc.keyed == req_desc.keyed) &&
                    (entry_desc.is_host == req_desc.is_host) &&
                    (entry_desc.source == req_desc.source);
   assign range_ok = !req_desc.keyed || (entry_desc.key_range == req_desc.key_range);

   // Host entries carry guest address zero
   assign entry_guest = entry_desc.is_host ? 32'd0 : entry_desc.source;

   assign flags.desc_hit  = base_eq && range_ok;
   assign flags.guest_hit = (entry_guest == req_desc.source);
   assign flags.hash_same = (entry_hash == req_hash);

endmodule

FILE: rtl/texture_pool_lookup_insert.sv
// Top level: texture descriptor pool with linear search, insert and dirty marking.
//
// Channel | Direction | Handshake           | Contents
// req     | in        | req_tvalid/tready   | tuser: mode, is_host; tdata: descriptor and hash
// rsp     | out       | rsp_tvalid/tready   | tdata: status, entry_index, entries_used, cleared
//
// Search: one stored entry is read from the descriptor memory and compared per cycle.
//   A lookup ends at the first hit; a miss appends a new entry or reports full, and a
//   dirty request visits every occupied entry. A zero size or a dirty request on an empty
//   pool goes straight to the response, an insert into an empty pool through the append step.
// Reset: clears the occupied count and the sequencer; entry memories are not cleared.
// Stalls: a new request is taken while a finished response waits on rsp.
module texture_pool_lookup_insert
   import tpli_pkg::*;
#(
   parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // tuser: mode [0], is_host [1]
   // tdata: source_id [31:0], tex_width [47:32], tex_height [63:48], is_keyed [64],
   //        key_low [96:65], key_high [128:97], content_hash [160:129], zero [167:161]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   // tdata: status [2:0], entry_index [11:3], entries_used [21:12], cleared_count [31:22]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = $clog2(POOL_DEPTH);
   localparam int CNT_W = $clog2(POOL_DEPTH + 1);

   // Entry memories
   desc_type    desc_mem [POOL_DEPTH];
   logic [31:0] hash_mem [POOL_DEPTH];

   state_type   state_ff, state_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [CNT_W-1:0] clr_cnt_ff, clr_cnt_in;
   status_type       wk_status_ff, wk_status_in;
   logic [IDX_W-1:0] wk_index_ff, wk_index_in;

   logic        rq_mode_ff, rq_mode_in;
   desc_type    rq_desc_ff, rq_desc_in;
   logic [31:0] rq_hash_ff, rq_hash_in;

   desc_type    desc_rd_ff;
   logic [31:0] hash_rd_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic             issue;
   logic             last_cmp;
   logic             req_accept;
   logic [IDX_W-1:0] rd_addr;
   logic             desc_we;
   logic             hash_we;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      hash_wdata;
   cmp_flags_type    flags;

   logic [15:0]      in_width;
   logic [15:0]      in_height;

   assign in_width   = req_tdata[47:32];
   assign in_height  = req_tdata[63:48];
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign issue    = (state_ff == S_SCAN) && (rd_idx_ff < used_ff);
   assign rd_addr  = rd_idx_ff[IDX_W-1:0];
   assign last_cmp = ((cmp_idx_ff + CNT_W'(1)) == used_ff);

   // Shared compare unit
   tpli_entry_cmp u_cmp (
      .entry_desc (desc_rd_ff),
      .entry_hash (hash_rd_ff),
      .req_desc   (rq_desc_ff),
      .req_hash   (rq_hash_ff),
      .flags      (flags)
   );

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (desc_we) begin
         desc_mem[wr_addr] <= rq_desc_ff;
      end
      if (hash_we) begin
         hash_mem[wr_addr] <= hash_wdata;
      end
      desc_rd_ff <= desc_mem[rd_addr];
      hash_rd_ff <= hash_mem[rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      clr_cnt_ff   <= clr_cnt_in;
      wk_status_ff <= wk_status_in;
      wk_index_ff  <= wk_index_in;
      rq_mode_ff   <= rq_mode_in;
      rq_desc_ff   <= rq_desc_in;
      rq_hash_ff   <= rq_hash_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Sequencer: next state, scan pointer, memory writes and response load
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_vld_in   = 1'b0;
      clr_cnt_in   = clr_cnt_ff;
      wk_status_in = wk_status_ff;
      wk_index_in  = wk_index_ff;
      rq_mode_in   = rq_mode_ff;
      rq_desc_in   = rq_desc_ff;
      rq_hash_in   = rq_hash_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      desc_we      = 1'b0;
      hash_we      = 1'b0;
      wr_addr      = cmp_idx_ff[IDX_W-1:0];
      hash_wdata   = rq_hash_ff;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rq_mode_in          = req_tuser[0];
               rq_desc_in.is_host  = req_tuser[1];
               rq_desc_in.source   = req_tdata[31:0];
               rq_desc_in.size     = {in_width, in_height};
               rq_desc_in.keyed    = req_tdata[64];
               rq_desc_in.key_range = {req_tdata[128:97], req_tdata[96:65]};
               rq_hash_in          = req_tdata[160:129];
               rd_idx_in           = '0;
               clr_cnt_in          = '0;
               wk_index_in         = '0;
               priority if (req_tuser[0] == MODE_DIRTY) begin
                  wk_status_in = ST_DIRTY;
                  state_in     = (used_ff == '0) ? S_DONE : S_SCAN;
               end else if ((in_width == 16'd0) || (in_height == 16'd0)) begin
                  wk_status_in = ST_INVALID;
                  state_in     = S_DONE;
               end else begin
                  state_in     = (used_ff == '0) ? S_MISS : S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // Advance the read pointer, one entry per cycle
            if (issue) begin
               rd_idx_in  = rd_idx_ff + CNT_W'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff;
            end
            if (cmp_vld_ff) begin
               if (rq_mode_ff == MODE_DIRTY) begin
                  // Zero the hash of every entry at this guest address
                  if (flags.guest_hit) begin
                     hash_we    = 1'b1;
                     hash_wdata = 32'd0;
                     clr_cnt_in = clr_cnt_ff + CNT_W'(1);
                  end
                  if (last_cmp) begin
                     cmp_vld_in = 1'b0;
                     state_in   = S_DONE;
                  end
               end else if (flags.desc_hit) begin
                  // First match ends the search
                  wk_index_in = cmp_idx_ff[IDX_W-1:0];
                  if (flags.hash_same) begin
                     wk_status_in = ST_HIT;
                  end else begin
                     wk_status_in = ST_REUPLOAD;
                     hash_we      = 1'b1;
                  end
                  cmp_vld_in = 1'b0;
                  state_in   = S_DONE;
               end else if (last_cmp) begin
                  cmp_vld_in = 1'b0;
                  state_in   = S_MISS;
               end
            end
         end

         S_MISS: begin
            // Append a new entry, or report full
            if (used_ff >= CNT_W'(POOL_DEPTH)) begin
               wk_status_in = ST_FULL;
               wk_index_in  = '0;
            end else begin
               wk_status_in = ST_INSERTED;
               wk_index_in  = used_ff[IDX_W-1:0];
               wr_addr      = used_ff[IDX_W-1:0];
               desc_we      = 1'b1;
               hash_we      = 1'b1;
               used_in      = used_ff + CNT_W'(1);
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {COUNT_W'(clr_cnt_ff), COUNT_W'(used_ff),
                               INDEX_W'(wk_index_ff), wk_status_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Occupancy never passes the pool depth
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(POOL_DEPTH))
      else $error("occupied count exceeds pool depth");

   // Compare slots exist only during a scan
   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == S_SCAN))
      else $error("compare slot outside scan");

   // A descriptor write is an append and grows the count by one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      desc_we |=> (used_ff == $past(used_ff) + CNT_W'(1)))
      else $error("insert without count update");

   // A response is raised only from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside done state");

   // No request is taken while a search is in progress
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) || (state_ff == S_MISS)) |-> !req_tready)
      else $error("ready during search");

endmodule

FILE: tb/sv/texture_pool_lookup_insert_check.sv
// Channel monitor for the texture pool: predicts every response and compares it field by field.
`timescale 1ns / 100ps

module texture_pool_lookup_insert_check
   import tpli_pkg::*;
#(
   parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    mismatch_count,
   output int                    outstanding
);

   // One response transaction, unpacked
   typedef struct packed {
      status_type         status;
      logic [INDEX_W-1:0] entry_index;
      logic [COUNT_W-1:0] entries_used;
      logic [COUNT_W-1:0] cleared_count;
   } pool_result_type;

   // Shadow copy of the descriptor pool
   desc_type    pool_desc [POOL_DEPTH];
   logic [31:0] pool_guest_addr [POOL_DEPTH];
   logic [31:0] pool_hash [POOL_DEPTH];
   int          pool_used = 0;

   pool_result_type expected_results [$];
   pool_result_type want;
   pool_result_type got;
   int              errors = 0;

   // Apply one request to the shadow pool and return the response it must give
   function automatic pool_result_type apply_request(input logic [REQ_USER_W-1:0] user,
                                                     input logic [REQ_DATA_W-1:0] data);
      pool_result_type res;
      desc_type        probe;
      logic [15:0]     width;
      logic [15:0]     height;
      logic [31:0]     hash;
      int              cleared;
      bit              found;
      res.status        = ST_HIT;
      res.entry_index   = '0;
      res.cleared_count = '0;
      probe.is_host     = user[1];
      probe.source      = data[31:0];
      width             = data[47:32];
      height            = data[63:48];
      probe.size        = {width, height};
      probe.keyed       = data[64];
      probe.key_range   = {data[128:97], data[96:65]};
      hash              = data[160:129];
      cleared           = 0;
      found             = 1'b0;

      if (user[0] == MODE_DIRTY) begin
         // zero the hash of every entry at this guest address
         for (int i = 0; i < pool_used; i++) begin
            if (pool_guest_addr[i] == probe.source) begin
               pool_hash[i] = '0;
               cleared++;
            end
         end
         res.status        = ST_DIRTY;
         res.cleared_count = cleared[COUNT_W-1:0];
      end else if (width == '0 || height == '0) begin
         res.status = ST_INVALID;
      end else begin
         // first matching entry wins; key range counts only when keyed
         for (int i = 0; i < pool_used; i++) begin
            if (!found && pool_desc[i].size == probe.size && pool_desc[i].keyed == probe.keyed
                && pool_desc[i].is_host == probe.is_host && pool_desc[i].source == probe.source
                && (!probe.keyed || pool_desc[i].key_range == probe.key_range)) begin
               found           = 1'b1;
               res.entry_index = i[INDEX_W-1:0];
               res.status      = (pool_hash[i] == hash) ? ST_HIT : ST_REUPLOAD;
               pool_hash[i]    = hash;
            end
         end
         if (!found) begin
            if (pool_used >= POOL_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               // append a new entry; host tiles carry guest address zero
               pool_desc[pool_used]       = probe;
               pool_guest_addr[pool_used] = probe.is_host ? 32'h0 : probe.source;
               pool_hash[pool_used]       = hash;
               res.status                 = ST_INSERTED;
               res.entry_index            = pool_used[INDEX_W-1:0];
               pool_used++;
            end
         end
      end
      res.entries_used = pool_used[COUNT_W-1:0];
      return res;
   endfunction

   // Report one field that differs
   task automatic check_field(input string name, input int expected_val, input int actual_val);
      if (expected_val != actual_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected_val,
                  actual_val);
         errors++;
      end
   endtask

   // Compare responses first, then record the request taken on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status        = status_type'(rsp_tdata[2:0]);
            got.entry_index   = rsp_tdata[11:3];
            got.entries_used  = rsp_tdata[21:12];
            got.cleared_count = rsp_tdata[31:22];
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response transaction, expected none, actual %h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", int'(want.status), int'(got.status));
               check_field("entry_index", int'(want.entry_index), int'(got.entry_index));
               check_field("entries_used", int'(want.entries_used), int'(got.entries_used));
               check_field("cleared_count", int'(want.cleared_count),
                           int'(got.cleared_count));
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_request(req_tuser, req_tdata));
      end
      outstanding    <= expected_results.size();
      mismatch_count <= errors;
   end

endmodule

FILE: tb/sv/texture_pool_lookup_insert_tb.sv
// Testbench top for the texture pool: clock, reset, request stimulus, response pacing, verdict.
`timescale 1ns / 100ps

module texture_pool_lookup_insert_tb;
   import tpli_pkg::*;

   localparam int CLOCK_HALF   = 6;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 640;
   localparam int HOLD_AFTER   = 40;
   localparam int HOLD_CYCLES  = 700;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 2_000_000;

   // Request content as the stimulus sees it
   typedef struct {
      logic        is_host;
      logic [31:0] source;
      logic [15:0] width;
      logic [15:0] height;
      logic        keyed;
      logic [31:0] key_low;
      logic [31:0] key_high;
      logic [31:0] hash;
   } surface_desc_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // tdata: source_id, tex_width, tex_height, is_keyed, key_low, key_high, content_hash, zero
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // tuser: mode, is_host
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // tdata: status, entry_index, entries_used, cleared_count
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int mismatch_count;
   int outstanding;

   // Descriptors that the stimulus believes are stored
   surface_desc_type surface_store [$];

   bit send_steady = 1'b0;
   bit take_steady = 1'b0;
   int rsp_wait    = 0;
   int rsp_taken   = 0;
   int next_wait;
   logic rsp_hold  = 1'b0;

   texture_pool_lookup_insert dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   texture_pool_lookup_insert_check pool_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Idle cycles before one transaction; none during a steady stretch
   function automatic int idle_cycles(input bit steady);
      return steady ? 0 : int'($urandom_range(0, 3));
   endfunction

   function automatic surface_desc_type make_desc(input logic is_host, input logic [31:0] source,
                                                  input logic [15:0] width,
                                                  input logic [15:0] height, input logic keyed,
                                                  input logic [31:0] key_low,
                                                  input logic [31:0] key_high,
                                                  input logic [31:0] hash);
      surface_desc_type d;
      d.is_host  = is_host;
      d.source   = source;
      d.width    = width;
      d.height   = height;
      d.keyed    = keyed;
      d.key_low  = key_low;
      d.key_high = key_high;
      d.hash     = hash;
      return d;
   endfunction

   // Random descriptor with the field extremes mixed in
   function automatic surface_desc_type random_desc();
      surface_desc_type d;
      d.is_host  = ($urandom_range(0, 9) < 3);
      d.source   = ($urandom_range(0, 19) == 0) ? 32'h0 : 32'($urandom);
      d.width    = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h1)
                                                : 16'($urandom_range(1, 65535));
      d.height   = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h1)
                                                : 16'($urandom_range(1, 65535));
      d.keyed    = 1'($urandom_range(0, 1));
      d.key_low  = ($urandom_range(0, 9) == 0) ? 32'h0 : 32'($urandom);
      d.key_high = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
      d.hash     = 32'($urandom);
      return d;
   endfunction

   // Offer one request transaction; valid stays high when no idle cycles follow
   task automatic offer(input logic mode, input surface_desc_type d);
      int gap;
      gap = idle_cycles(send_steady);
      if ($urandom_range(0, 63) == 0)
         send_steady = !send_steady;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {d.is_host, mode};
      req_tdata  <= {7'd0, d.hash, d.key_high, d.key_low, d.keyed, d.height, d.width, d.source};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Offer a lookup that should insert, and remember it while the pool has room
   task automatic add_entry(input surface_desc_type d);
      offer(MODE_LOOKUP, d);
      if (surface_store.size() < POOL_DEPTH_DEF)
         surface_store.push_back(d);
   endtask

   // Pace the response side, with the long hold-off forced from its own process
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
      end else begin
         next_wait = rsp_wait;
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken <= rsp_taken + 1;
            next_wait = idle_cycles(take_steady);
            if ($urandom_range(0, 63) == 0)
               take_steady = !take_steady;
         end else if (next_wait > 0) begin
            next_wait--;
         end
         rsp_wait   <= next_wait;
         rsp_tready <= (next_wait == 0) && !rsp_hold;
      end
   end

   // Hold off the receiver long enough for the block to fill and stall its input
   initial begin
      while (rsp_taken < HOLD_AFTER) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Abort a hung run
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      surface_desc_type a;
      surface_desc_type b;
      surface_desc_type c;
      surface_desc_type d;
      surface_desc_type pal;
      int pick;
      int variant;
      int new_limit;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Dirty request on an empty pool at address zero, other fields all ones
      offer(MODE_DIRTY, make_desc(1'b1, 32'h0, 16'hFFFF, 16'hFFFF, 1'b1, '1, '1, '1));
      // Zero width, zero height, both zero
      offer(MODE_LOOKUP, make_desc(1'b0, 32'h40, 16'h0, 16'h10, 1'b0, '0, '0, 32'h5));
      offer(MODE_LOOKUP, make_desc(1'b1, 32'h40, 16'h10, 16'h0, 1'b1, '1, '1, 32'h5));
      offer(MODE_LOOKUP, make_desc(1'b0, '1, 16'h0, 16'h0, 1'b0, '0, '0, '0));

      // Keyed guest surface at the field extremes: insert, hit, reupload, new key range
      a = make_desc(1'b0, '1, 16'hFFFF, 16'hFFFF, 1'b1, 32'h0, '1, '1);
      add_entry(a);
      offer(MODE_LOOKUP, a);
      a.hash = '0;
      offer(MODE_LOOKUP, a);
      a.key_low = 32'h1;
      add_entry(a);

      // Host tile: the key range is ignored when unkeyed
      b = make_desc(1'b1, 32'h0, 16'h1, 16'h1, 1'b0, '1, 32'h0, 32'h0);
      add_entry(b);
      b.key_low  = '0;
      b.key_high = '1;
      offer(MODE_LOOKUP, b);

      // Same guest address under several sizes and keyed flags, plus a host tile with that id
      c = make_desc(1'b0, 32'h1234, 16'h8, 16'h8, 1'b0, '0, '0, 32'hA5A5_A5A5);
      add_entry(c);
      c.width = 16'h10;
      add_entry(c);
      c.keyed = 1'b1;
      add_entry(c);
      c.is_host = 1'b1;
      add_entry(c);
      offer(MODE_DIRTY, make_desc(1'b0, 32'h1234, '0, '0, 1'b0, '0, '0, '0));
      // Hash was zeroed by the dirty request, so this one reuploads
      c = make_desc(1'b0, 32'h1234, 16'h8, 16'h8, 1'b0, '0, '0, 32'hA5A5_A5A5);
      offer(MODE_LOOKUP, c);

      // Guest surface at address zero shares the dirty address of the host tiles
      add_entry(make_desc(1'b0, 32'h0, 16'h2, 16'h3, 1'b0, '0, '0, 32'h77));
      offer(MODE_DIRTY, make_desc(1'b1, 32'h0, '1, '1, 1'b1, '1, '1, '1));
      offer(MODE_DIRTY, make_desc(1'b0, 32'h0, '0, '0, 1'b0, '0, '0, '0));
      offer(MODE_DIRTY, make_desc(1'b0, 32'hDEAD_0001, '0, '0, 1'b0, '0, '0, '0));

      // Mostly fresh descriptors until the pool fills, then mostly repeats and full reports
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick      = $urandom_range(0, 99);
         new_limit = (surface_store.size() < POOL_DEPTH_DEF) ? 94 : 40;
         if (pick < 6) begin
            // dirty by a stored guest address, address zero via host tiles, or random
            d = random_desc();
            if (surface_store.size() > 0 && $urandom_range(0, 3) != 0) begin
               pal      = surface_store[$urandom_range(0, surface_store.size() - 1)];
               d.source = pal.is_host ? 32'h0 : pal.source;
            end
            offer(MODE_DIRTY, d);
         end else if (pick < 9) begin
            d = random_desc();
            case ($urandom_range(0, 2))
               0: begin
                  d.width = '0;
               end
               1: begin
                  d.height = '0;
               end
               default: begin
                  d.width  = '0;
                  d.height = '0;
               end
            endcase
            offer(MODE_LOOKUP, d);
         end else if (surface_store.size() == 0 || pick < new_limit) begin
            // fresh descriptor, sometimes sharing an existing source id
            d = random_desc();
            if (surface_store.size() > 0 && $urandom_range(0, 3) == 0)
               d.source = surface_store[$urandom_range(0, surface_store.size() - 1)].source;
            add_entry(d);
         end else begin
            // repeat a stored descriptor: exact, new hash, or new key range
            d       = surface_store[$urandom_range(0, surface_store.size() - 1)];
            variant = $urandom_range(0, 3);
            case (variant)
               1: begin
                  d.hash = 32'($urandom);
               end
               2: begin
                  d.key_low  = 32'($urandom);
                  d.key_high = 32'($urandom);
               end
               default: begin
               end
            endcase
            if (variant == 2 && d.keyed)
               add_entry(d);
            else
               offer(MODE_LOOKUP, d);
         end
      end

      // Drain, then give the verdict
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/tpli_pkg.sv
rtl/tpli_entry_cmp.sv
rtl/texture_pool_lookup_insert.sv
tb/sv/texture_pool_lookup_insert_check.sv
tb/sv/texture_pool_lookup_insert_tb.sv
